// ===== hdl/gauge_matrix_spinor_multiply_assert.svh =====
// Assertion macros included by gauge_matrix_spinor_multiply.sv.
`ifndef GAUGE_MATRIX_SPINOR_MULTIPLY_ASSERT_SVH
`define GAUGE_MATRIX_SPINOR_MULTIPLY_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GMS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define GMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/gms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gms_pkg;

    localparam int COLOR_DIM_DEF = 3;
    localparam int SPIN_DIM      = 4;
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    // Sum of up to 4*6 products of magnitude 2^62 stays below 2^67.
    localparam int ACC_W         = PROD_W + 4;
    localparam int FRAC_W        = 24;

    localparam logic [1:0] OP_LOAD_MATRIX = 2'd0;
    localparam logic [1:0] OP_LOAD_SPINOR = 2'd1;
    localparam logic [1:0] OP_COMPUTE     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic issue;    // operands valid this cycle
        logic to_imag;  // product goes to the imaginary accumulator
        logic negate;   // subtract instead of add
        logic clear;    // zero both accumulators
    } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/gauge_matrix_spinor_multiply.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Complex gauge matrix (COLOR_DIM x COLOR_DIM) times spinor (COLOR_DIM x 4), Q8.24.
// Load beats write one matrix or spinor entry; loads with an index out of range and
// op 3 are dropped. A compute beat emits 4*COLOR_DIM result beats, colour-major then
// spin, tlast on the final one. One 32x32 multiplier is shared for every product:
// each of the COLOR_DIM terms of a result takes a RAM read state and then four
// multiply phases, and each result then passes a drain and an emit state; the emit
// state waits while the output is stalled. The input is not ready while a product runs.
// Entries never loaded since reset read as unknown.

module gauge_matrix_spinor_multiply
    import gms_pkg::*;
#(
    parameter int COLOR_DIM = COLOR_DIM_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // op[1:0], row_index[4:2], col_index[7:5],
                                        // re_value[39:8], im_value[71:40]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // color_index[2:0], spin_index[4:3],
                                        // re_result[36:5], im_result[68:37], zero[71:69]
    output logic             m_tlast
);

    localparam int CW      = (COLOR_DIM > 1) ? $clog2(COLOR_DIM) : 1;
    localparam int MDEPTH  = COLOR_DIM * COLOR_DIM;
    localparam int SDEPTH  = COLOR_DIM * SPIN_DIM;
    localparam int MAW     = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
    localparam int SAW     = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int RAM_W   = 2 * DATA_W;

    logic [1:0]        in_op;
    logic [2:0]        in_row;
    logic [2:0]        in_col;
    logic [DATA_W-1:0] in_re;
    logic [DATA_W-1:0] in_im;
    logic              in_beat;

    state_t state_reg, state_next;
    logic [CW-1:0] c_reg, c_next;
    logic [CW-1:0] j_reg, j_next;
    logic [1:0]    s_reg, s_next;
    logic [1:0]    ph_reg, ph_next;

    logic              mat_wr_en;
    logic              spn_wr_en;
    logic [MAW-1:0]    mat_wr_addr;
    logic [SAW-1:0]    spn_wr_addr;
    logic [MAW-1:0]    mat_rd_addr;
    logic [SAW-1:0]    spn_rd_addr;
    logic [RAM_W-1:0]  mat_rd_data;
    logic [RAM_W-1:0]  spn_rd_data;

    mac_ctrl_t                mac_ctrl;
    logic signed [DATA_W-1:0] opnd_a;
    logic signed [DATA_W-1:0] opnd_b;
    logic signed [DATA_W-1:0] re_round;
    logic signed [DATA_W-1:0] im_round;
    logic                     mac_busy;

    logic              out_load;
    logic              out_valid_reg;
    logic [2:0]        out_color_reg;
    logic [1:0]        out_spin_reg;
    logic [DATA_W-1:0] out_re_reg;
    logic [DATA_W-1:0] out_im_reg;
    logic              out_last_reg;
    logic              last_entry;

    assign in_op   = s_tdata[1:0];
    assign in_row  = s_tdata[4:2];
    assign in_col  = s_tdata[7:5];
    assign in_re   = s_tdata[39:8];
    assign in_im   = s_tdata[71:40];
    assign in_beat = s_tvalid && s_tready;

    assign s_tready = (state_reg == ST_IDLE);

    // Store writes: drop out-of-range indexes.
    assign mat_wr_en = in_beat && (in_op == OP_LOAD_MATRIX)
                       && (int'(in_row) < COLOR_DIM) && (int'(in_col) < COLOR_DIM);
    assign spn_wr_en = in_beat && (in_op == OP_LOAD_SPINOR)
                       && (int'(in_row) < COLOR_DIM) && (int'(in_col) < SPIN_DIM);
    assign mat_wr_addr = MAW'(int'(in_row) * COLOR_DIM + int'(in_col));
    assign spn_wr_addr = SAW'(int'(in_row) * SPIN_DIM + int'(in_col));
    assign mat_rd_addr = MAW'(int'(c_reg) * COLOR_DIM + int'(j_reg));
    assign spn_rd_addr = SAW'(int'(j_reg) * SPIN_DIM + int'(s_reg));

    gms_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MDEPTH)
    ) u_mat_ram (
        .clk     (clk),
        .wr_en   (mat_wr_en),
        .wr_addr (mat_wr_addr),
        .wr_data ({in_im, in_re}),
        .rd_addr (mat_rd_addr),
        .rd_data (mat_rd_data)
    );

    gms_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SDEPTH)
    ) u_spn_ram (
        .clk     (clk),
        .wr_en   (spn_wr_en),
        .wr_addr (spn_wr_addr),
        .wr_data ({in_im, in_re}),
        .rd_addr (spn_rd_addr),
        .rd_data (spn_rd_data)
    );

    // Phase 0: mr*sr, 1: -mi*si, 2: mr*si, 3: mi*sr.
    assign opnd_a = ph_reg[0] ? mat_rd_data[RAM_W-1:DATA_W] : mat_rd_data[DATA_W-1:0];
    assign opnd_b = (ph_reg[0] ^ ph_reg[1]) ? spn_rd_data[RAM_W-1:DATA_W]
                                            : spn_rd_data[DATA_W-1:0];

    gms_cmac u_cmac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mac_ctrl),
        .opnd_a   (opnd_a),
        .opnd_b   (opnd_b),
        .re_round (re_round),
        .im_round (im_round),
        .busy     (mac_busy)
    );

    assign last_entry = (c_reg == CW'(COLOR_DIM - 1)) && (s_reg == 2'(SPIN_DIM - 1));

    always_comb
    begin
        state_next = state_reg;
        c_next     = c_reg;
        j_next     = j_reg;
        s_next     = s_reg;
        ph_next    = ph_reg;
        mac_ctrl   = '0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat && (in_op == OP_COMPUTE))
                begin
                    c_next     = '0;
                    j_next     = '0;
                    s_next     = '0;
                    ph_next    = '0;
                    mac_ctrl.clear = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                ph_next    = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                mac_ctrl.issue   = 1'b1;
                mac_ctrl.to_imag = ph_reg[1];
                mac_ctrl.negate  = (ph_reg == 2'd1);
                ph_next          = ph_reg + 2'd1;
                if (ph_reg == 2'd3)
                begin
                    if (j_reg == CW'(COLOR_DIM - 1))
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        j_next     = j_reg + CW'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load       = 1'b1;
                    mac_ctrl.clear = 1'b1;
                    j_next         = '0;
                    if (last_entry)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                        if (s_reg == 2'(SPIN_DIM - 1))
                        begin
                            s_next = '0;
                            c_next = c_reg + CW'(1);
                        end
                        else
                        begin
                            s_next = s_reg + 2'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            c_reg         <= '0;
            j_reg         <= '0;
            s_reg         <= '0;
            ph_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            c_reg     <= c_next;
            j_reg     <= j_next;
            s_reg     <= s_next;
            ph_reg    <= ph_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_color_reg <= 3'(c_reg);
            out_spin_reg  <= s_reg;
            out_re_reg    <= re_round;
            out_im_reg    <= im_round;
            out_last_reg  <= last_entry;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_im_reg, out_re_reg, out_spin_reg, out_color_reg};

`include "gauge_matrix_spinor_multiply_assert.svh"

    // Accumulators must have absorbed the last product before a result is taken.
    `GMS_ASSERT_NOW(a_emit_after_drain, out_load, !mac_busy)
    `GMS_ASSERT_NEXT(a_load_shows, out_load, out_valid_reg)
    `GMS_ASSERT_NOW(a_last_pos, m_tvalid && m_tlast,
        (out_color_reg == 3'(COLOR_DIM - 1)) && (out_spin_reg == 2'(SPIN_DIM - 1)))
    `GMS_ASSERT_NEXT(a_drain_to_emit, state_reg == ST_DRAIN, state_reg == ST_EMIT)

endmodule

`default_nettype wire

// ===== hdl/gms_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gms_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/gms_cmac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gms_cmac
    import gms_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire mac_ctrl_t                ctrl,
    input  wire logic signed [DATA_W-1:0] opnd_a,
    input  wire logic signed [DATA_W-1:0] opnd_b,
    output logic signed      [DATA_W-1:0] re_round,
    output logic signed      [DATA_W-1:0] im_round,
    output logic                          busy
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic                     prod_imag_reg;
    logic                     prod_neg_reg;
    logic signed [ACC_W-1:0]  acc_re_reg;
    logic signed [ACC_W-1:0]  acc_im_reg;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  acc_sel;
    logic signed [ACC_W-1:0]  acc_next;

    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0]        biased;
        logic signed [ACC_W-FRAC_W-1:0] shifted;
        logic signed [DATA_W-1:0]       res;
        biased  = acc + ACC_W'(1 << (FRAC_W - 1));
        shifted = biased[ACC_W-1:FRAC_W];
        if (!shifted[ACC_W-FRAC_W-1] && (|shifted[ACC_W-FRAC_W-2:DATA_W-1]))
        begin
            res = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (shifted[ACC_W-FRAC_W-1] && !(&shifted[ACC_W-FRAC_W-2:DATA_W-1]))
        begin
            res = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            res = shifted[DATA_W-1:0];
        end
        return res;
    endfunction

    assign prod_ext = ACC_W'(prod_reg);
    assign acc_sel  = prod_imag_reg ? acc_im_reg : acc_re_reg;
    assign acc_next = prod_neg_reg ? (acc_sel - prod_ext) : (acc_sel + prod_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= PROD_W'(opnd_a) * PROD_W'(opnd_b);
        prod_imag_reg <= ctrl.to_imag;
        prod_neg_reg  <= ctrl.negate;
        if (ctrl.clear)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            if (prod_imag_reg)
            begin
                acc_im_reg <= acc_next;
            end
            else
            begin
                acc_re_reg <= acc_next;
            end
        end
    end

    assign re_round = round_sat(acc_re_reg);
    assign im_round = round_sat(acc_im_reg);
    assign busy     = prod_valid_reg;

endmodule

`default_nettype wire

// ===== dv/tb_gauge_matrix_spinor_multiply.sv =====
`timescale 1ns / 1ps

module tb_gauge_matrix_spinor_multiply;
    import gms_pkg::*;

    localparam int N              = COLOR_DIM_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 40;

    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam logic [31:0] S32_MIN   = 32'h8000_0000;
    localparam logic [31:0] S32_MAX   = 32'h7fff_ffff;
    localparam logic [31:0] Q_ONE     = 32'h0100_0000;
    localparam logic [31:0] HALF_LSB  = 32'h0080_0000;

    typedef struct {
        logic [2:0]  color;
        logic [1:0]  spin;
        logic [31:0] re;
        logic [31:0] im;
        logic        last;
    } entry_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [71:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [71:0] m_tdata;
    logic        m_tlast;

    entry_t      expected_entries[$];
    int          fail_count         = 0;
    int          stalled_cycles     = 0;
    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;

    // Shadow copy of the matrix and spinor stores
    logic signed [31:0] mat_re[N*N];
    logic signed [31:0] mat_im[N*N];
    logic signed [31:0] spn_re[N*SPIN_DIM];
    logic signed [31:0] spn_im[N*SPIN_DIM];
    bit                 mat_written[N*N];
    bit                 spn_written[N*SPIN_DIM];

    gauge_matrix_spinor_multiply #(
        .COLOR_DIM (N)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    function automatic logic [71:0] make_item(logic [1:0] op, logic [2:0] row, logic [2:0] col,
                                              logic [31:0] re, logic [31:0] im);
        return {im, re, col, row, op};
    endfunction

    // Round Q16.48 to Q8.24, ties toward +inf, then clamp to 32 bits
    function automatic logic [31:0] round_saturate(logic signed [127:0] sum);
        logic signed [127:0] q;
        q = (sum + 128'sd8388608) >>> FRAC_W;
        if (q > 128'sd2147483647)
            return S32_MAX;
        if (q < -128'sd2147483648)
            return S32_MIN;
        return q[31:0];
    endfunction

    function automatic bit all_entries_loaded();
        foreach (mat_written[i])
            if (!mat_written[i])
                return 1'b0;
        foreach (spn_written[i])
            if (!spn_written[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void push_product_entries();
        logic signed [127:0] acc_re;
        logic signed [127:0] acc_im;
        longint              mr;
        longint              mi;
        longint              sr;
        longint              si;
        entry_t              e;
        for (int c = 0; c < N; c++)
        begin
            for (int s = 0; s < SPIN_DIM; s++)
            begin
                acc_re = '0;
                acc_im = '0;
                for (int j = 0; j < N; j++)
                begin
                    mr = longint'(mat_re[c*N + j]);
                    mi = longint'(mat_im[c*N + j]);
                    sr = longint'(spn_re[j*SPIN_DIM + s]);
                    si = longint'(spn_im[j*SPIN_DIM + s]);
                    acc_re = acc_re + mr * sr;
                    acc_re = acc_re - mi * si;
                    acc_im = acc_im + mr * si;
                    acc_im = acc_im + mi * sr;
                end
                e.color = 3'(c);
                e.spin  = 2'(s);
                e.re    = round_saturate(acc_re);
                e.im    = round_saturate(acc_im);
                e.last  = (c == N - 1) && (s == SPIN_DIM - 1);
                expected_entries.push_back(e);
            end
        end
    endfunction

    function automatic void apply_item(logic [71:0] item);
        logic [1:0]  op;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] re;
        logic [31:0] im;
        op  = item[1:0];
        row = item[4:2];
        col = item[7:5];
        re  = item[39:8];
        im  = item[71:40];
        case (op)
            OP_LOAD_MATRIX:
                if (row < N && col < N)
                begin
                    mat_re[row*N + col]      = re;
                    mat_im[row*N + col]      = im;
                    mat_written[row*N + col] = 1'b1;
                end
            OP_LOAD_SPINOR:
                if (row < N && col < SPIN_DIM)
                begin
                    spn_re[row*SPIN_DIM + col]      = re;
                    spn_im[row*SPIN_DIM + col]      = im;
                    spn_written[row*SPIN_DIM + col] = 1'b1;
                end
            OP_COMPUTE:
                push_product_entries();
            default:
                ;
        endcase
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(9))
            0:       return S32_MIN;
            1:       return S32_MAX;
            2:       return '0;
            3, 4, 5: return $urandom;
            // within +/-1.0, keeps most sums clear of saturation
            default: return 32'($urandom_range(32'h0200_0000)) - Q_ONE;
        endcase
    endfunction

    task automatic send_item(logic [71:0] item);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        do
            @(posedge clk);
        while (!s_tready);
        apply_item(item);
    endtask

    task automatic quiet_sender();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_product_drained();
        quiet_sender();
        while (expected_entries.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_valid_load(bit to_matrix);
        if (to_matrix)
            send_item(make_item(OP_LOAD_MATRIX, 3'($urandom_range(N - 1)),
                                3'($urandom_range(N - 1)), rand_value(), rand_value()));
        else
            send_item(make_item(OP_LOAD_SPINOR, 3'($urandom_range(N - 1)),
                                3'($urandom_range(SPIN_DIM - 1)), rand_value(), rand_value()));
    endtask

    task automatic send_compute();
        send_item(make_item(OP_COMPUTE, 3'($urandom_range(7)), 3'($urandom_range(7)),
                            $urandom, $urandom));
    endtask

    task automatic send_ignored_item();
        logic [2:0] row;
        logic [2:0] col;
        row = 3'($urandom_range(7));
        col = 3'($urandom_range(7));
        case ($urandom_range(2))
            0:
                send_item(make_item(OP_UNUSED, row, col, $urandom, $urandom));
            1:
            begin
                if (row < N && col < N)
                    col = 3'($urandom_range(7, N));
                send_item(make_item(OP_LOAD_MATRIX, row, col, $urandom, $urandom));
            end
            default:
            begin
                if (row < N && col < SPIN_DIM)
                    row = 3'($urandom_range(7, N));
                send_item(make_item(OP_LOAD_SPINOR, row, col, $urandom, $urandom));
            end
        endcase
    endtask

    // Rows 0 and 1 drive the sums into both saturation limits; the last row adds
    // half-LSB terms in both signs, to sums that saturate as well.
    task automatic test_extreme_values();
        logic [31:0] vr;
        logic [31:0] vi;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        for (int r = 0; r < N; r++)
        begin
            for (int c = 0; c < N; c++)
            begin
                if (r == 0)
                begin
                    vr = S32_MIN;
                    vi = S32_MIN;
                end
                else if (r == 1)
                begin
                    vr = S32_MAX;
                    vi = S32_MIN;
                end
                else if (c == N - 1)
                begin
                    vr = 32'd1;
                    vi = '0;
                end
                else if (c == 0)
                begin
                    vr = Q_ONE;
                    vi = '0;
                end
                else
                begin
                    vr = '0;
                    vi = Q_ONE;
                end
                send_item(make_item(OP_LOAD_MATRIX, 3'(r), 3'(c), vr, vi));
            end
        end
        for (int r = 0; r < N; r++)
        begin
            for (int s = 0; s < SPIN_DIM; s++)
            begin
                if (r == 0)
                begin
                    vr = S32_MIN;
                    vi = S32_MAX;
                end
                else if (r < N - 1)
                begin
                    vr = S32_MAX;
                    vi = S32_MAX;
                end
                else
                begin
                    case (s)
                        0:       begin vr = HALF_LSB;  vi = -HALF_LSB; end
                        1:       begin vr = -HALF_LSB; vi = HALF_LSB;  end
                        2:       begin vr = S32_MIN;   vi = '0;        end
                        default: begin vr = '0;        vi = S32_MAX;   end
                    endcase
                end
                send_item(make_item(OP_LOAD_SPINOR, 3'(r), 3'(s), vr, vi));
            end
        end
        send_compute();
    endtask

    // Out-of-range loads and the unused opcode must leave both stores alone
    task automatic test_ignored_items();
        send_item(make_item(OP_UNUSED, 3'd7, 3'd7, S32_MAX, S32_MAX));
        send_item(make_item(OP_LOAD_MATRIX, 3'(N), 3'd0, S32_MAX, S32_MAX));
        send_item(make_item(OP_LOAD_SPINOR, 3'd0, 3'(SPIN_DIM), S32_MAX, S32_MAX));
        send_item(make_item(OP_LOAD_SPINOR, 3'd7, 3'd3, S32_MAX, S32_MAX));
        send_compute();
    endtask

    task automatic test_pause_until_drained();
        sender_idle_pct    = 31;
        receiver_stall_pct = 31;
        repeat (2)
        begin
            repeat (3)
                send_valid_load(1'b0);
            send_valid_load(1'b1);
            send_compute();
            wait_product_drained();
        end
    endtask

    task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
        int sent;
        int pick;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        sent               = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 10 && all_entries_loaded())
            begin
                send_compute();
                sent++;
            end
            else if (pick < 88)
            begin
                send_valid_load(pick < 50);
                sent++;
            end
            else
                send_ignored_item();
        end
    endtask

    task automatic finish_run();
        wait_product_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge clk)
    begin : result_check
        entry_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_entries.size() == 0)
            begin
                $error("unexpected result beat: color %0d spin %0d", m_tdata[2:0], m_tdata[4:3]);
                fail_count++;
            end
            else
            begin
                want = expected_entries.pop_front();
                check_field("color_index", 32'(want.color), 32'(m_tdata[2:0]));
                check_field("spin_index", 32'(want.spin), 32'(m_tdata[4:3]));
                check_field("re_result", want.re, m_tdata[36:5]);
                check_field("im_result", want.im, m_tdata[68:37]);
                check_field("pad", '0, 32'(m_tdata[71:69]));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    // Abort when neither side has moved a beat for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extreme_values();
        test_ignored_items();
        test_pause_until_drained();
        test_random_traffic(33, 0, 0);
        test_random_traffic(33, 72, 0);
        test_random_traffic(33, 0, 72);
        test_random_traffic(33, 31, 31);
        finish_run();
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/gms_pkg.sv
hdl/gms_ram.sv
hdl/gms_cmac.sv
hdl/gauge_matrix_spinor_multiply.sv
dv/tb_gauge_matrix_spinor_multiply.sv
